[hdl/cce_pkg.sv]
package cce_pkg;

  // Character width of the input and output streams.
  localparam int CHAR_W = 16;
  // Longest replacement token, in characters.
  localparam int TOK_MAX_LEN = 11;
  // Length of a script-string escape: backslash, 'u' and four hex digits.
  localparam int UNI_LEN = 6;
  localparam int IDX_W = 4;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Escaping contexts held in the mode register.
  localparam logic [3:0] MODE_NETNAME  = 4'd0;
  localparam logic [3:0] MODE_LIBID    = 4'd1;
  localparam logic [3:0] MODE_LEGACY   = 4'd2;
  localparam logic [3:0] MODE_IPC      = 4'd3;
  localparam logic [3:0] MODE_QUOTED   = 4'd4;
  localparam logic [3:0] MODE_SCRIPT   = 4'd5;
  localparam logic [3:0] MODE_LINE     = 4'd6;
  localparam logic [3:0] MODE_FILENAME = 4'd7;
  localparam logic [3:0] MODE_NOSPACE  = 4'd8;
  localparam logic [3:0] MODE_CSV      = 4'd9;
  localparam logic [3:0] MODE_NONE     = 4'd10;

  // Character codes that the classifier and the expander use.
  localparam char_t CH_TAB      = char_t'(8'h09);
  localparam char_t CH_LF       = char_t'(8'h0A);
  localparam char_t CH_CR       = char_t'(8'h0D);
  localparam char_t CH_SPACE    = char_t'(8'h20);
  localparam char_t CH_DQUOTE   = char_t'(8'h22);
  localparam char_t CH_SQUOTE   = char_t'(8'h27);
  localparam char_t CH_LPAREN   = char_t'(8'h28);
  localparam char_t CH_RPAREN   = char_t'(8'h29);
  localparam char_t CH_COMMA    = char_t'(8'h2C);
  localparam char_t CH_SLASH    = char_t'(8'h2F);
  localparam char_t CH_COLON    = char_t'(8'h3A);
  localparam char_t CH_LT       = char_t'(8'h3C);
  localparam char_t CH_GT       = char_t'(8'h3E);
  localparam char_t CH_BSLASH   = char_t'(8'h5C);
  localparam char_t CH_U        = char_t'(8'h75);
  localparam char_t CH_BAR      = char_t'(8'h7C);
  localparam char_t CH_DEL      = char_t'(8'h7F);

  typedef enum logic [3:0] {
    TOK_SLASH,
    TOK_BACKSLASH,
    TOK_LT,
    TOK_GT,
    TOK_COLON,
    TOK_DBLQUOTE,
    TOK_COMMA,
    TOK_RETURN,
    TOK_TAB,
    TOK_SPACE,
    TOK_BAR
  } tok_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_TOKEN,
    KIND_UNICODE
  } kind_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    kind_t kind;
    tok_t  tok;
    char_t ch;
  } cce_entry_t;

  // Token text, right-justified.
  function automatic logic [8*TOK_MAX_LEN-1:0] tok_text(tok_t t);
    logic [8*TOK_MAX_LEN-1:0] txt;
    unique case (t)
      TOK_SLASH:     txt = (8*TOK_MAX_LEN)'("{slash}");
      TOK_BACKSLASH: txt = (8*TOK_MAX_LEN)'("{backslash}");
      TOK_LT:        txt = (8*TOK_MAX_LEN)'("{lt}");
      TOK_GT:        txt = (8*TOK_MAX_LEN)'("{gt}");
      TOK_COLON:     txt = (8*TOK_MAX_LEN)'("{colon}");
      TOK_DBLQUOTE:  txt = (8*TOK_MAX_LEN)'("{dblquote}");
      TOK_COMMA:     txt = (8*TOK_MAX_LEN)'("{comma}");
      TOK_RETURN:    txt = (8*TOK_MAX_LEN)'("{return}");
      TOK_TAB:       txt = (8*TOK_MAX_LEN)'("{tab}");
      TOK_SPACE:     txt = (8*TOK_MAX_LEN)'("{space}");
      TOK_BAR:       txt = (8*TOK_MAX_LEN)'("{bar}");
      default:       txt = '0;
    endcase
    return txt;
  endfunction

  // Token length in characters.
  function automatic idx_t tok_len(tok_t t);
    idx_t len;
    unique case (t)
      TOK_SLASH:     len = idx_t'(7);
      TOK_BACKSLASH: len = idx_t'(11);
      TOK_LT:        len = idx_t'(4);
      TOK_GT:        len = idx_t'(4);
      TOK_COLON:     len = idx_t'(7);
      TOK_DBLQUOTE:  len = idx_t'(10);
      TOK_COMMA:     len = idx_t'(7);
      TOK_RETURN:    len = idx_t'(8);
      TOK_TAB:       len = idx_t'(5);
      TOK_SPACE:     len = idx_t'(7);
      TOK_BAR:       len = idx_t'(5);
      default:       len = idx_t'(1);
    endcase
    return len;
  endfunction

  // Character at position idx of a token.
  function automatic logic [7:0] tok_char(tok_t t, idx_t idx);
    logic [8*TOK_MAX_LEN-1:0] txt;
    logic [8*TOK_MAX_LEN-1:0] lj;
    logic [7:0]               res;
    txt = tok_text(t);
    lj  = txt << (8 * (TOK_MAX_LEN - int'(tok_len(t))));
    res = 8'h00;
    for (int i = 0; i < TOK_MAX_LEN; i++) begin
      if (int'(idx) == i) begin
        res = lj[8*(TOK_MAX_LEN-1-i) +: 8];
      end
    end
    return res;
  endfunction

  // Uppercase hex digit.
  function automatic logic [7:0] hex_char(logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
  endfunction

endpackage

[hdl/cce_front.sv]
module cce_front import cce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] escape_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  char_t      in_char,
  output logic       push_valid,
  output cce_entry_t push_entry,
  input  logic       push_ready
);

  logic [3:0] mode;
  logic       nl;
  logic       tok_hit;
  logic       uni_hit;
  logic       drop;
  tok_t       tok;

  // The mode register takes every configuration transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (cfg_valid) begin
      mode <= escape_mode;
    end
  end

  // Classify the character under the current context.
  assign nl = (in_char == CH_LF) || (in_char == CH_CR);

  always_comb begin
    tok_hit = 1'b0;
    uni_hit = 1'b0;
    drop    = 1'b0;
    tok     = TOK_SLASH;
    unique case (mode)
      MODE_NETNAME: begin
        if (in_char == CH_SLASH) begin
          tok_hit = 1'b1;
        end else if (nl) begin
          drop = 1'b1;
        end
      end
      MODE_LIBID, MODE_LEGACY: begin
        tok_hit = 1'b1;
        if (in_char == CH_SLASH && mode == MODE_LEGACY) begin
          tok = TOK_SLASH;
        end else if (in_char == CH_BSLASH) begin
          tok = TOK_BACKSLASH;
        end else if (in_char == CH_LT) begin
          tok = TOK_LT;
        end else if (in_char == CH_GT) begin
          tok = TOK_GT;
        end else if (in_char == CH_COLON) begin
          tok = TOK_COLON;
        end else if (in_char == CH_DQUOTE) begin
          tok = TOK_DBLQUOTE;
        end else begin
          tok_hit = 1'b0;
          drop    = nl;
        end
      end
      MODE_IPC: begin
        tok_hit = 1'b1;
        if (in_char == CH_SLASH) begin
          tok = TOK_SLASH;
        end else if (in_char == CH_COMMA) begin
          tok = TOK_COMMA;
        end else if (in_char == CH_DQUOTE) begin
          tok = TOK_DBLQUOTE;
        end else begin
          tok_hit = 1'b0;
        end
      end
      MODE_QUOTED: begin
        tok_hit = (in_char == CH_DQUOTE);
        tok     = TOK_DBLQUOTE;
      end
      MODE_SCRIPT: begin
        uni_hit = (in_char >= CH_DEL) || (in_char == CH_SQUOTE) ||
                  (in_char == CH_BSLASH) || (in_char == CH_LPAREN) ||
                  (in_char == CH_RPAREN);
      end
      MODE_LINE: begin
        tok_hit = nl;
        tok     = TOK_RETURN;
      end
      MODE_FILENAME: begin
        tok_hit = 1'b1;
        if (in_char == CH_SLASH) begin
          tok = TOK_SLASH;
        end else if (in_char == CH_BSLASH) begin
          tok = TOK_BACKSLASH;
        end else if (in_char == CH_DQUOTE) begin
          tok = TOK_DBLQUOTE;
        end else if (in_char == CH_LT) begin
          tok = TOK_LT;
        end else if (in_char == CH_GT) begin
          tok = TOK_GT;
        end else if (in_char == CH_BAR) begin
          tok = TOK_BAR;
        end else if (in_char == CH_COLON) begin
          tok = TOK_COLON;
        end else if (in_char == CH_TAB) begin
          tok = TOK_TAB;
        end else if (nl) begin
          tok = TOK_RETURN;
        end else begin
          tok_hit = 1'b0;
        end
      end
      MODE_NOSPACE: begin
        tok_hit = (in_char == CH_SPACE);
        tok     = TOK_SPACE;
      end
      MODE_CSV: begin
        tok_hit = 1'b1;
        if (in_char == CH_COMMA) begin
          tok = TOK_COMMA;
        end else if (nl) begin
          tok = TOK_RETURN;
        end else begin
          tok_hit = 1'b0;
        end
      end
      default: begin
        tok_hit = 1'b0;
      end
    endcase
  end

  // Dropped characters are consumed without a queue entry.
  assign in_ready         = push_ready;
  assign push_valid       = in_valid && !drop;
  assign push_entry.kind  = uni_hit ? KIND_UNICODE : (tok_hit ? KIND_TOKEN : KIND_PLAIN);
  assign push_entry.tok   = tok;
  assign push_entry.ch    = in_char;

endmodule

[hdl/cce_queue.sv]
module cce_queue import cce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  cce_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop,
  output cce_entry_t pop_entry
);

  cce_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[hdl/cce_back.sv]
module cce_back import cce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cce_entry_t q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output char_t      out_char,
  output logic       run_last
);

  idx_t  idx;
  idx_t  last_idx;
  char_t cur_char;
  logic  load;
  logic  at_last;

  // Final position of the run for the entry at the queue head.
  always_comb begin
    case (q_entry.kind)
      KIND_TOKEN:   last_idx = tok_len(q_entry.tok) - idx_t'(1);
      KIND_UNICODE: last_idx = idx_t'(UNI_LEN - 1);
      default:      last_idx = '0;
    endcase
  end

  // Character at the current run position.
  always_comb begin
    case (q_entry.kind)
      KIND_TOKEN: cur_char = char_t'(tok_char(q_entry.tok, idx));
      KIND_UNICODE: begin
        case (idx)
          idx_t'(0): cur_char = CH_BSLASH;
          idx_t'(1): cur_char = CH_U;
          idx_t'(2): cur_char = char_t'(hex_char(q_entry.ch[15:12]));
          idx_t'(3): cur_char = char_t'(hex_char(q_entry.ch[11:8]));
          idx_t'(4): cur_char = char_t'(hex_char(q_entry.ch[7:4]));
          default:   cur_char = char_t'(hex_char(q_entry.ch[3:0]));
        endcase
      end
      default: cur_char = q_entry.ch;
    endcase
  end

  // Load the output register from the queue head whenever an entry waits and the register is empty or being drained.
  assign load    = q_valid && (!out_valid || out_ready);
  assign at_last = (idx == last_idx);
  assign q_pop   = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_last ? '0 : idx + idx_t'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= cur_char;
      run_last <= at_last;
    end
  end

  // The run position never passes the end of the entry it walks.
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> idx <= last_idx)
    else $error("run position beyond end of entry");

  // A run in progress keeps its entry at the queue head.
  a_run_holds_entry: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> q_valid)
    else $error("run in progress without a queue entry");

  // A plain character leaves as a single-character run.
  a_plain_single: assert property (@(posedge clk) disable iff (rst)
    load && q_entry.kind == KIND_PLAIN |=> out_valid && run_last)
    else $error("plain character not marked as run end");

endmodule

[hdl/context_char_escaper.sv]
// Context character escaper.
// Each result is registered in the two-entry queue and then in the output register.
// Throughput: one plain character per cycle while out_ready is held high; an escaped
// character holds the output side for its whole run (4 to 11 characters for a token, 6 for a \uXXXX run).
// Reset (rst, synchronous) empties the two-entry queue and the output register
// and sets the escaping context to pass-through.
module context_char_escaper import cce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] escape_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  char_t      in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output char_t      out_char,
  output logic       run_last
);

  logic       push_valid;
  logic       push_ready;
  cce_entry_t push_entry;
  logic       q_valid;
  logic       q_pop;
  cce_entry_t q_entry;

  // Classification front end.
  cce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .escape_mode(escape_mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decoupling queue between front and back.
  cce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  // Run expansion back end.
  cce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .run_last   (run_last)
  );

endmodule
